FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while the design is out of reset.
`define SEGI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Checked at every edge, reset cycles included.
`define SEGI_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define SEGI_ASSERT(label, clk, rst_n, prop)
`define SEGI_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/segi_pkg.sv
// ---------------------------------------------------------------------------
// Segment intersection package
// Types shared between the front end and the top level.
// ---------------------------------------------------------------------------
package segi_pkg;

    // How the result of one segment pair is formed.
    typedef enum logic [1:0] {
        CASE_NONE      = 2'd0,
        CASE_GENERAL   = 2'd1,
        CASE_COLLINEAR = 2'd2
    } t_case;

endpackage

FILE: rtl/segi_if.sv
// ---------------------------------------------------------------------------
// Segment intersection channels
// Valid/ready channels for segment pairs and for intersection results.
// ---------------------------------------------------------------------------
interface segi_in_if #(
    parameter int COORD_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

interface segi_out_if #(
    parameter int COORD_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

FILE: rtl/segi_front.sv
// ---------------------------------------------------------------------------
// Segment intersection front end
// Six pipeline stages: differences, cross products, determinant, sign
// normalization, case selection with scaled numerator, divider operands.
// ---------------------------------------------------------------------------
module segi_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    segi_in_if.sink                     i_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [3*COORD_BITS+5:0]     o_rem_x,
    output logic [3*COORD_BITS+5:0]     o_rem_y,
    output logic [3*COORD_BITS+5:0]     o_den,
    output segi_pkg::t_case             o_kind,
    output logic signed [COORD_BITS-1:0] o_alt_x,
    output logic signed [COORD_BITS-1:0] o_alt_y,
    output logic signed [COORD_BITS-1:0] o_base_x,
    output logic signed [COORD_BITS-1:0] o_base_y,
    output logic                        o_neg_x,
    output logic                        o_neg_y
);
    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    localparam int NL = C + 2;
    localparam int NH = NW - NL;
    localparam int RW = 3 * C + 6;
    localparam int QB = C + 1;

    logic en1, en2, en3, en4, en5, en6;
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r6_valid;

    // Stage 1: edge vectors and the offset between the start points.
    logic signed [DW-1:0] r1_v0x, r1_v0y, r1_v1x, r1_v1y, r1_dx, r1_dy;
    logic signed [C-1:0]  r1_ax1, r1_ay1, r1_ax2, r1_ay2;
    logic signed [C-1:0]  r1_bx1, r1_by1, r1_bx2, r1_by2;

    // Stage 2: products and collinear span tests.
    logic signed [PW-1:0] r2_pd1, r2_pd2, r2_pa1, r2_pa2, r2_pb1, r2_pb2;
    logic signed [DW-1:0] r2_v0x, r2_v0y;
    logic signed [C-1:0]  r2_ax1, r2_ay1, r2_bx1, r2_by1, r2_bx2, r2_by2;
    logic signed [C-1:0]  r2_lo, r2_hi;
    logic                 r2_nz, r2_vert, r2_b1in, r2_b2in, r2_a1in;
    logic signed [C-1:0]  n_amin, n_amax, n_bmin, n_bmax, n_aymin, n_aymax;
    logic signed [C-1:0]  n_bymin, n_bymax;

    // Stage 3: determinant, numerators and the collinear candidate point.
    logic signed [NW-1:0] r3_det, r3_na, r3_nb;
    logic signed [DW-1:0] r3_v0x, r3_v0y;
    logic signed [C-1:0]  r3_ax1, r3_ay1, r3_alt_x, r3_alt_y;
    logic                 r3_nz, r3_alt_ok;
    logic signed [C-1:0]  n_alt_x, n_alt_y;
    logic                 n_alt_ok;

    // Stage 4: determinant made positive, span magnitudes.
    logic [NW-1:0]        r4_det, r4_na, r4_nb;
    logic [DW-1:0]        r4_mx, r4_my;
    logic                 r4_neg_x, r4_neg_y, r4_gen, r4_colin;
    logic signed [C-1:0]  r4_ax1, r4_ay1, r4_alt_x, r4_alt_y;
    logic                 n_det_neg;

    // Stage 5: case decision and partial products of span times numerator.
    logic [DW+NL-1:0]     r5_plx, r5_ply;
    logic [DW+NH-1:0]     r5_phx, r5_phy;
    logic [NW-1:0]        r5_det;
    segi_pkg::t_case      r5_kind;
    logic                 r5_neg_x, r5_neg_y;
    logic signed [C-1:0]  r5_ax1, r5_ay1, r5_alt_x, r5_alt_y;
    logic                 n_gen_ok;

    // Stage 6: rounded-division operands.
    logic [RW-1:0]        r6_rem_x, r6_rem_y, r6_den;
    segi_pkg::t_case      r6_kind;
    logic                 r6_neg_x, r6_neg_y;
    logic signed [C-1:0]  r6_ax1, r6_ay1, r6_alt_x, r6_alt_y;
    logic [RW-1:0]        n_px, n_py;

    // A stage loads when it is empty or its successor loads this cycle.
    assign en6        = !r6_valid || i_ready;
    assign en5        = !r5_valid || en6;
    assign en4        = !r4_valid || en5;
    assign en3        = !r3_valid || en4;
    assign en2        = !r2_valid || en3;
    assign en1        = !r1_valid || en2;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_in.valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
            if (en5) r5_valid <= r4_valid;
            if (en6) r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_v0x <= DW'(i_in.a_end_x) - DW'(i_in.a_start_x);
            r1_v0y <= DW'(i_in.a_end_y) - DW'(i_in.a_start_y);
            r1_v1x <= DW'(i_in.b_end_x) - DW'(i_in.b_start_x);
            r1_v1y <= DW'(i_in.b_end_y) - DW'(i_in.b_start_y);
            r1_dx  <= DW'(i_in.a_start_x) - DW'(i_in.b_start_x);
            r1_dy  <= DW'(i_in.a_start_y) - DW'(i_in.b_start_y);
            r1_ax1 <= i_in.a_start_x;
            r1_ay1 <= i_in.a_start_y;
            r1_ax2 <= i_in.a_end_x;
            r1_ay2 <= i_in.a_end_y;
            r1_bx1 <= i_in.b_start_x;
            r1_by1 <= i_in.b_start_y;
            r1_bx2 <= i_in.b_end_x;
            r1_by2 <= i_in.b_end_y;
        end
    end

    always_comb begin
        n_amin  = (r1_ax1 < r1_ax2) ? r1_ax1 : r1_ax2;
        n_amax  = (r1_ax1 < r1_ax2) ? r1_ax2 : r1_ax1;
        n_bmin  = (r1_bx1 < r1_bx2) ? r1_bx1 : r1_bx2;
        n_bmax  = (r1_bx1 < r1_bx2) ? r1_bx2 : r1_bx1;
        n_aymin = (r1_ay1 < r1_ay2) ? r1_ay1 : r1_ay2;
        n_aymax = (r1_ay1 < r1_ay2) ? r1_ay2 : r1_ay1;
        n_bymin = (r1_by1 < r1_by2) ? r1_by1 : r1_by2;
        n_bymax = (r1_by1 < r1_by2) ? r1_by2 : r1_by1;
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_pd1  <= PW'(r1_v1x) * PW'(r1_v0y);
            r2_pd2  <= PW'(r1_v0x) * PW'(r1_v1y);
            r2_pa1  <= PW'(r1_dx) * PW'(r1_v1y);
            r2_pa2  <= PW'(r1_dy) * PW'(r1_v1x);
            r2_pb1  <= PW'(r1_dx) * PW'(r1_v0y);
            r2_pb2  <= PW'(r1_dy) * PW'(r1_v0x);
            r2_v0x  <= r1_v0x;
            r2_v0y  <= r1_v0y;
            r2_nz   <= ((r1_v0x != '0) || (r1_v0y != '0)) &&
                       ((r1_v1x != '0) || (r1_v1y != '0));
            r2_vert <= (r1_v0x == '0);
            r2_b1in <= (r1_bx1 >= n_amin) && (r1_bx1 <= n_amax);
            r2_b2in <= (r1_bx2 >= n_amin) && (r1_bx2 <= n_amax);
            r2_a1in <= (r1_ax1 >= n_bmin) && (r1_ax1 <= n_bmax);
            r2_lo   <= (n_aymin > n_bymin) ? n_aymin : n_bymin;
            r2_hi   <= (n_aymax < n_bymax) ? n_aymax : n_bymax;
            r2_ax1  <= r1_ax1;
            r2_ay1  <= r1_ay1;
            r2_bx1  <= r1_bx1;
            r2_by1  <= r1_by1;
            r2_bx2  <= r1_bx2;
            r2_by2  <= r1_by2;
        end
    end

    // Collinear candidate; for a vertical line the overlap's lower end.
    always_comb begin
        n_alt_ok = 1'b1;
        n_alt_x  = r2_ax1;
        n_alt_y  = r2_ay1;
        priority if (r2_vert) begin
            n_alt_ok = (r2_lo <= r2_hi);
            n_alt_y  = r2_lo;
        end else if (r2_b1in) begin
            n_alt_x = r2_bx1;
            n_alt_y = r2_by1;
        end else if (r2_b2in) begin
            n_alt_x = r2_bx2;
            n_alt_y = r2_by2;
        end else begin
            n_alt_ok = r2_a1in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_det    <= NW'(r2_pd1) - NW'(r2_pd2);
            r3_na     <= NW'(r2_pa1) - NW'(r2_pa2);
            r3_nb     <= NW'(r2_pb1) - NW'(r2_pb2);
            r3_v0x    <= r2_v0x;
            r3_v0y    <= r2_v0y;
            r3_nz     <= r2_nz;
            r3_ax1    <= r2_ax1;
            r3_ay1    <= r2_ay1;
            r3_alt_ok <= n_alt_ok;
            r3_alt_x  <= n_alt_x;
            r3_alt_y  <= n_alt_y;
        end
    end

    assign n_det_neg = r3_det[NW-1];

    // With a zero determinant the collinearity cross product equals nb.
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_det   <= n_det_neg ? NW'(-r3_det) : NW'(r3_det);
            r4_na    <= n_det_neg ? NW'(-r3_na) : NW'(r3_na);
            r4_nb    <= n_det_neg ? NW'(-r3_nb) : NW'(r3_nb);
            r4_mx    <= r3_v0x[DW-1] ? DW'(-r3_v0x) : DW'(r3_v0x);
            r4_my    <= r3_v0y[DW-1] ? DW'(-r3_v0y) : DW'(r3_v0y);
            r4_neg_x <= r3_v0x[DW-1];
            r4_neg_y <= r3_v0y[DW-1];
            r4_gen   <= r3_nz && (r3_det != '0);
            r4_colin <= r3_nz && (r3_det == '0) && (r3_nb == '0) && r3_alt_ok;
            r4_ax1   <= r3_ax1;
            r4_ay1   <= r3_ay1;
            r4_alt_x <= r3_alt_x;
            r4_alt_y <= r3_alt_y;
        end
    end

    assign n_gen_ok = r4_gen && !r4_na[NW-1] && (r4_na <= r4_det) &&
                      !r4_nb[NW-1] && (r4_nb <= r4_det);

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_plx   <= (DW+NL)'(r4_mx) * (DW+NL)'(r4_na[NL-1:0]);
            r5_phx   <= (DW+NH)'(r4_mx) * (DW+NH)'(r4_na[NW-1:NL]);
            r5_ply   <= (DW+NL)'(r4_my) * (DW+NL)'(r4_na[NL-1:0]);
            r5_phy   <= (DW+NH)'(r4_my) * (DW+NH)'(r4_na[NW-1:NL]);
            r5_det   <= r4_det;
            r5_kind  <= n_gen_ok ? segi_pkg::CASE_GENERAL :
                        r4_colin ? segi_pkg::CASE_COLLINEAR : segi_pkg::CASE_NONE;
            r5_neg_x <= r4_neg_x;
            r5_neg_y <= r4_neg_y;
            r5_ax1   <= r4_ax1;
            r5_ay1   <= r4_ay1;
            r5_alt_x <= r4_alt_x;
            r5_alt_y <= r4_alt_y;
        end
    end

    assign n_px = (RW'(r5_phx) << NL) + RW'(r5_plx);
    assign n_py = (RW'(r5_phy) << NL) + RW'(r5_ply);

    // Rounded quotient: floor((2*span*na + det) / (2*det)).
    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_rem_x <= (n_px << 1) + RW'(r5_det);
            r6_rem_y <= (n_py << 1) + RW'(r5_det);
            r6_den   <= RW'(r5_det) << QB;
            r6_kind  <= r5_kind;
            r6_neg_x <= r5_neg_x;
            r6_neg_y <= r5_neg_y;
            r6_ax1   <= r5_ax1;
            r6_ay1   <= r5_ay1;
            r6_alt_x <= r5_alt_x;
            r6_alt_y <= r5_alt_y;
        end
    end

    assign o_valid  = r6_valid;
    assign o_rem_x  = r6_rem_x;
    assign o_rem_y  = r6_rem_y;
    assign o_den    = r6_den;
    assign o_kind   = r6_kind;
    assign o_alt_x  = r6_alt_x;
    assign o_alt_y  = r6_alt_y;
    assign o_base_x = r6_ax1;
    assign o_base_y = r6_ay1;
    assign o_neg_x  = r6_neg_x;
    assign o_neg_y  = r6_neg_y;

endmodule

FILE: rtl/segi_div_cell.sv
// ---------------------------------------------------------------------------
// Segment intersection divider cell
// One restoring-division step for both coordinates; passes its result on.
// ---------------------------------------------------------------------------
module segi_div_cell #(
    parameter int RW     = 78,
    parameter int QB     = 25,
    parameter int INFO_W = 100
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RW-1:0]     i_rem_x,
    input  logic [RW-1:0]     i_rem_y,
    input  logic [QB-1:0]     i_q_x,
    input  logic [QB-1:0]     i_q_y,
    input  logic [RW-1:0]     i_den,
    input  logic [INFO_W-1:0] i_info,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [RW-1:0]     o_rem_x,
    output logic [RW-1:0]     o_rem_y,
    output logic [QB-1:0]     o_q_x,
    output logic [QB-1:0]     o_q_y,
    output logic [RW-1:0]     o_den,
    output logic [INFO_W-1:0] o_info
);
    logic              r_valid;
    logic [RW-1:0]     r_rem_x, r_rem_y, r_den;
    logic [QB-1:0]     r_q_x, r_q_y;
    logic [INFO_W-1:0] r_info;
    logic              en, n_ge_x, n_ge_y;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign n_ge_x  = (i_rem_x >= i_den);
    assign n_ge_y  = (i_rem_y >= i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem_x <= n_ge_x ? (i_rem_x - i_den) : i_rem_x;
            r_rem_y <= n_ge_y ? (i_rem_y - i_den) : i_rem_y;
            r_q_x   <= {i_q_x[QB-2:0], n_ge_x};
            r_q_y   <= {i_q_y[QB-2:0], n_ge_y};
            r_den   <= i_den >> 1;
            r_info  <= i_info;
        end
    end

    assign o_valid = r_valid;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;
    assign o_den   = r_den;
    assign o_info  = r_info;

endmodule

FILE: rtl/segment_intersection.sv
// ---------------------------------------------------------------------------
// Segment intersection
// Pipelined 2-D line segment intersection test with one result per pair.
// ---------------------------------------------------------------------------
// Usage: each transaction on i_in carries the two endpoints of segment A and
// of segment B as signed fixed-point coordinates (Q15.8 at the default width;
// the fraction point only sets their meaning, the arithmetic is exact). Every
// input transaction yields exactly one transaction on o_out: hit, and the
// meeting point, which reads as zero when hit is low.
// The pipeline holds six front-end stages, one divider cell per quotient bit
// (COORD_BITS + 1 cells, each of which settles one bit of both coordinates with
// one wide subtract and compare per coordinate) and the output register. A new
// pair is taken in every cycle unless a stalled receiver has filled the chain.
// Every stage carries a valid bit and loads whenever it is empty or its
// successor loads, so when the receiver stalls the results queue up behind
// the output register and empty stages still take transactions until the
// whole chain is full. Reset clears all valid bits; data registers are not
// reset. The design has no state from one pair to the next.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection #(
    parameter int COORD_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    segi_in_if.sink   i_in,
    segi_out_if.source o_out
);
    localparam int C      = COORD_BITS;
    localparam int RW     = 3 * C + 6;
    localparam int QB     = C + 1;
    localparam int KW     = $bits(segi_pkg::t_case);
    localparam int INFO_W = KW + 4 * C + 2;

    // Chain links: index k feeds cell k, index QB is the last cell's output.
    logic              l_valid [QB+1];
    logic              l_ready [QB+1];
    logic [RW-1:0]     l_rem_x [QB+1];
    logic [RW-1:0]     l_rem_y [QB+1];
    logic [QB-1:0]     l_q_x   [QB+1];
    logic [QB-1:0]     l_q_y   [QB+1];
    logic [RW-1:0]     l_den   [QB+1];
    logic [INFO_W-1:0] l_info  [QB+1];

    segi_pkg::t_case     f_kind;
    logic signed [C-1:0] f_alt_x, f_alt_y, f_base_x, f_base_y;
    logic                f_neg_x, f_neg_y;

    segi_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (l_valid[0]),
        .i_ready (l_ready[0]),
        .o_rem_x (l_rem_x[0]),
        .o_rem_y (l_rem_y[0]),
        .o_den   (l_den[0]),
        .o_kind  (f_kind),
        .o_alt_x (f_alt_x),
        .o_alt_y (f_alt_y),
        .o_base_x(f_base_x),
        .o_base_y(f_base_y),
        .o_neg_x (f_neg_x),
        .o_neg_y (f_neg_y)
    );

    assign l_q_x[0]  = '0;
    assign l_q_y[0]  = '0;
    assign l_info[0] = {KW'(f_kind), f_alt_x, f_alt_y, f_base_x, f_base_y,
                        f_neg_x, f_neg_y};

    // The divider: one cell per quotient bit, most significant bit first.
    for (genvar k = 0; k < QB; k++) begin : g_cell
        segi_div_cell #(
            .RW    (RW),
            .QB    (QB),
            .INFO_W(INFO_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(l_valid[k]),
            .o_ready(l_ready[k]),
            .i_rem_x(l_rem_x[k]),
            .i_rem_y(l_rem_y[k]),
            .i_q_x  (l_q_x[k]),
            .i_q_y  (l_q_y[k]),
            .i_den  (l_den[k]),
            .i_info (l_info[k]),
            .o_valid(l_valid[k+1]),
            .i_ready(l_ready[k+1]),
            .o_rem_x(l_rem_x[k+1]),
            .o_rem_y(l_rem_y[k+1]),
            .o_q_x  (l_q_x[k+1]),
            .o_q_y  (l_q_y[k+1]),
            .o_den  (l_den[k+1]),
            .o_info (l_info[k+1])
        );
    end

    // Final stage: apply the quotient to the start point of A, or take the collinear point.
    logic [KW-1:0]       e_kind_bits;
    segi_pkg::t_case     e_kind;
    logic signed [C-1:0] e_alt_x, e_alt_y, e_base_x, e_base_y;
    logic                e_neg_x, e_neg_y;
    logic signed [C+1:0] e_sum_x, e_sum_y;
    logic                n_hit;
    logic signed [C-1:0] n_x, n_y;
    logic                r_o_valid, r_o_hit, en_out;
    logic signed [C-1:0] r_o_x, r_o_y;

    assign {e_kind_bits, e_alt_x, e_alt_y, e_base_x, e_base_y, e_neg_x, e_neg_y} =
        l_info[QB];
    assign e_kind = segi_pkg::t_case'(e_kind_bits);

    // The point lies between the endpoints of A, so the low bits are exact.
    assign e_sum_x = e_neg_x ? ((C+2)'(e_base_x) - $signed((C+2)'(l_q_x[QB])))
                             : ((C+2)'(e_base_x) + $signed((C+2)'(l_q_x[QB])));
    assign e_sum_y = e_neg_y ? ((C+2)'(e_base_y) - $signed((C+2)'(l_q_y[QB])))
                             : ((C+2)'(e_base_y) + $signed((C+2)'(l_q_y[QB])));

    always_comb begin
        unique case (e_kind)
            segi_pkg::CASE_GENERAL: begin
                n_hit = 1'b1;
                n_x   = e_sum_x[C-1:0];
                n_y   = e_sum_y[C-1:0];
            end
            segi_pkg::CASE_COLLINEAR: begin
                n_hit = 1'b1;
                n_x   = e_alt_x;
                n_y   = e_alt_y;
            end
            default: begin
                n_hit = 1'b0;
                n_x   = '0;
                n_y   = '0;
            end
        endcase
    end

    assign en_out      = !r_o_valid || o_out.ready;
    assign l_ready[QB] = en_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_out) begin
            r_o_valid <= l_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_o_hit <= n_hit;
            r_o_x   <= n_x;
            r_o_y   <= n_y;
        end
    end

    assign o_out.valid   = r_o_valid;
    assign o_out.hit     = r_o_hit;
    assign o_out.cross_x = r_o_x;
    assign o_out.cross_y = r_o_y;

    // A result without a hit carries a zero point.
    `SEGI_ASSERT(a_miss_zero, i_clk, i_rst_n, o_out.valid && !o_out.hit |-> (o_out.cross_x == '0) && (o_out.cross_y == '0))
    // With the output register empty every stage can load, so input is taken.
    `SEGI_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out.valid |-> i_in.ready)
    // Reset empties the output register.
    `SEGI_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out.valid)

endmodule

FILE: test/segment_intersection_tb.sv
// ---------------------------------------------------------------------------
// Segment intersection testbench
// Drives segment pairs through the valid/ready input channel and checks each
// result transaction against an exact integer predictor of the intersection.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_intersection_tb;

    localparam int COORD_BITS = 24;
    localparam int LATENCY    = COORD_BITS + 8;
    localparam int WATCHDOG   = 4000;
    localparam int N_RANDOM   = 630;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    } t_pair;

    typedef struct packed {
        logic   hit;
        t_coord x;
        t_coord y;
    } t_meet;

    // One row of the directed table: a pair and, where it is obvious, the result.
    typedef struct {
        t_pair pair;
        logic  known;
        t_meet meet;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    segi_in_if  #(.COORD_BITS(COORD_BITS)) seg_in ();
    segi_out_if #(.COORD_BITS(COORD_BITS)) seg_out ();

    segment_intersection #(.COORD_BITS(COORD_BITS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (seg_in.sink),
        .o_out   (seg_out.source)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_meet meet_queue[$];
    int    mismatches;
    int    meets_seen;
    int    hits_seen;
    int    idle_cycles;
    bit    sink_stalls;   // the receiver stalls only while this is set

    // Prints one line per mismatching field and counts it.
    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Rounded interpolation offset round(span * num / den), ties away from zero,
    // with 0 <= num <= den. The result always fits within span.
    function automatic longint lerp_offset(longint span, logic signed [127:0] num,
                                           logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (span < 0) ? -span : span;
        q   = (2 * num * mag + den) / (2 * den);
        return (span < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit in_span(longint v, longint e1, longint e2);
        return v >= (e1 < e2 ? e1 : e2) && v <= (e1 < e2 ? e2 : e1);
    endfunction

    // Works out where two segments meet. Wide signed math keeps every product exact.
    function automatic t_meet meet_point(t_pair p);
        longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        longint v0x, v0y, v1x, v1y, dx, dy, lo, hi;
        logic signed [127:0] det, na, nb, cr;
        t_meet m;
        ax1 = p.ax1; ay1 = p.ay1; ax2 = p.ax2; ay2 = p.ay2;
        bx1 = p.bx1; by1 = p.by1; bx2 = p.bx2; by2 = p.by2;
        v0x = ax2 - ax1; v0y = ay2 - ay1;
        v1x = bx2 - bx1; v1y = by2 - by1;
        dx  = ax1 - bx1; dy  = ay1 - by1;
        m = '0;
        // A segment of zero length never counts as a hit.
        if ((v0x == 0 && v0y == 0) || (v1x == 0 && v1y == 0)) return m;
        det = 128'(v1x) * v0y - 128'(v0x) * v1y;
        if (det == 0) begin
            cr = 128'(v0x) * (-dy) - 128'(v0y) * (-dx);
            if (cr != 0) return m;   // parallel but apart
            if (v0x == 0) begin
                // Vertical and collinear: overlap of the two y spans.
                lo = (ay1 < ay2 ? ay1 : ay2);
                if ((by1 < by2 ? by1 : by2) > lo) lo = (by1 < by2 ? by1 : by2);
                hi = (ay1 < ay2 ? ay2 : ay1);
                if ((by1 < by2 ? by2 : by1) < hi) hi = (by1 < by2 ? by2 : by1);
                if (lo <= hi) begin
                    m.hit = 1'b1; m.x = t_coord'(ax1); m.y = t_coord'(lo);
                end
            end else if (in_span(bx1, ax1, ax2)) begin
                m.hit = 1'b1; m.x = t_coord'(bx1); m.y = t_coord'(by1);
            end else if (in_span(bx2, ax1, ax2)) begin
                m.hit = 1'b1; m.x = t_coord'(bx2); m.y = t_coord'(by2);
            end else if (in_span(ax1, bx1, bx2)) begin
                m.hit = 1'b1; m.x = t_coord'(ax1); m.y = t_coord'(ay1);
            end
            return m;
        end
        na = 128'(dx) * v1y - 128'(dy) * v1x;
        nb = 128'(dx) * v0y - 128'(dy) * v0x;
        if (det < 0) begin
            det = -det; na = -na; nb = -nb;
        end
        if (na >= 0 && na <= det && nb >= 0 && nb <= det) begin
            m.hit = 1'b1;
            m.x = t_coord'(ax1 + lerp_offset(v0x, na, det));
            m.y = t_coord'(ay1 + lerp_offset(v0y, na, det));
        end
        return m;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0:       return t_coord'($urandom);
            1:       return $urandom_range(0, 1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                                 : {1'b1, {(COORD_BITS-1){1'b0}}};
            default: return t_coord'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // Mostly crossing or touching pairs, some collinear and degenerate ones.
    function automatic t_pair rand_pair();
        t_pair  p;
        longint ox, oy, kx, ky;
        int     s1, s2;
        p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        case ($urandom_range(0, 9))
            0, 1: ;   // fully random
            2: begin   // collinear on a random line
                ox = $signed($urandom_range(0, 2000)) - 1000;
                oy = $signed($urandom_range(0, 2000)) - 1000;
                kx = $signed($urandom_range(0, 20)) - 10;
                ky = $signed($urandom_range(0, 20)) - 10;
                if ($urandom_range(0, 2) == 0) kx = 0;
                if (kx == 0 && ky == 0) ky = 3;
                s1 = $signed($urandom_range(0, 40)) - 20;
                s2 = $signed($urandom_range(0, 40)) - 20;
                p.ax1 = t_coord'(ox); p.ay1 = t_coord'(oy);
                p.ax2 = t_coord'(ox + kx * s1); p.ay2 = t_coord'(oy + ky * s1);
                s1 = $signed($urandom_range(0, 40)) - 20;
                p.bx1 = t_coord'(ox + kx * s1); p.by1 = t_coord'(oy + ky * s1);
                p.bx2 = t_coord'(ox + kx * s2); p.by2 = t_coord'(oy + ky * s2);
            end
            3: begin   // parallel offset, or a zero-length segment
                p.bx1 = p.ax1 + 5; p.by1 = p.ay1;
                p.bx2 = p.ax2 + 5; p.by2 = p.ay2;
                if ($urandom_range(0, 1)) begin
                    p.bx2 = p.bx1; p.by2 = p.by1;
                end
            end
            default: begin   // B runs through a point of A, so a hit is likely
                p.bx1 = t_coord'((longint'(p.ax1) + p.ax2) / 2 - (p.bx2 - p.ax1) / 3);
                p.by1 = t_coord'((longint'(p.ay1) + p.ay2) / 2 - (p.by2 - p.ay1) / 3);
                if ($urandom_range(0, 3) == 0) begin
                    p.bx1 = p.ax2; p.by1 = p.ay2;   // touching at an end
                end
            end
        endcase
        return p;
    endfunction

    localparam t_coord MAXC = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord MINC = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Directed rows; expected results are filled in only where they are plain.
    t_row rows[] = '{
        '{'{0, 0, 256, 256, 0, 256, 256, 0}, 1'b1, '{1'b1, 128, 128}},
        '{'{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC}, 1'b0, '0},
        '{'{MINC, 0, MAXC, 0, 0, MINC, 0, MAXC}, 1'b1, '{1'b1, 0, 0}},
        '{'{MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC}, 1'b0, '0},
        '{'{5, 5, 5, 5, 0, 0, 9, 9}, 1'b1, '0},
        '{'{0, 0, 9, 9, 3, 3, 3, 3}, 1'b1, '0},
        '{'{0, 0, 9, 0, 0, 1, 9, 1}, 1'b1, '0},
        '{'{4, 0, 4, 10, 4, 5, 4, 20}, 1'b1, '{1'b1, 4, 5}},
        '{'{4, 0, 4, 10, 4, 10, 4, 20}, 1'b1, '{1'b1, 4, 10}},
        '{'{4, 0, 4, 10, 4, 11, 4, 20}, 1'b1, '0},
        '{'{0, 0, 10, 10, 5, 5, 20, 20}, 1'b1, '{1'b1, 5, 5}},
        '{'{0, 0, 10, 10, 20, 20, 5, 5}, 1'b1, '{1'b1, 5, 5}},
        '{'{2, 2, 4, 4, 0, 0, 10, 10}, 1'b1, '{1'b1, 2, 2}},
        '{'{0, 0, 4, 4, 5, 5, 9, 9}, 1'b1, '0},
        '{'{0, 0, 10, 0, 10, 0, 10, 7}, 1'b1, '{1'b1, 10, 0}},
        '{'{0, 0, 10, 0, 11, 0, 11, 7}, 1'b0, '0},
        '{'{0, 0, 3, 1, 1, -5, 2, 5}, 1'b0, '0},
        '{'{0, 0, -3, 7, 0, 2, -5, 1}, 1'b0, '0},
        '{'{MINC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC}, 1'b1,
          '{1'b1, MAXC, MINC}},
        '{'{MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC}, 1'b1, '0}
    };

    // Puts one pair on the channel and waits for its acceptance. The sender may
    // insert a burst of idle cycles first.
    task automatic send_pair(input t_pair p, input t_meet want, input bit bursts);
        if (bursts && $urandom_range(0, 5) == 0) begin
            seg_in.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        meet_queue.push_back(want);
        seg_in.valid     <= 1'b1;
        seg_in.a_start_x <= p.ax1; seg_in.a_start_y <= p.ay1;
        seg_in.a_end_x   <= p.ax2; seg_in.a_end_y   <= p.ay2;
        seg_in.b_start_x <= p.bx1; seg_in.b_start_y <= p.by1;
        seg_in.b_end_x   <= p.bx2; seg_in.b_end_y   <= p.by2;
        do @(posedge i_clk); while (!seg_in.ready);
    endtask

    // The receiver stalls in bursts while sink_stalls is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_out.ready <= 1'b0;
        end else if (sink_stalls && seg_out.ready && $urandom_range(0, 5) == 0) begin
            seg_out.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
            seg_out.ready <= 1'b1;
        end else begin
            seg_out.ready <= 1'b1;
        end
    end

    // Checks every result transaction against the oldest pending expectation.
    always @(posedge i_clk) begin
        t_meet want;
        if (i_rst_n && seg_out.valid && seg_out.ready) begin
            meets_seen++;
            if (meet_queue.size() == 0) begin
                report("result count", meets_seen, meets_seen - 1);
            end else begin
                want = meet_queue.pop_front();
                if (seg_out.hit !== want.hit) report("hit", seg_out.hit, want.hit);
                if (seg_out.cross_x !== want.x) report("cross_x", seg_out.cross_x, want.x);
                if (seg_out.cross_y !== want.y) report("cross_y", seg_out.cross_y, want.y);
                if (want.hit) hits_seen++;
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((seg_in.valid && seg_in.ready) || (seg_out.valid && seg_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("timeout after %0d cycles without a transaction", WATCHDOG);
            $display("segment_intersection regression: fail");
            $finish;
        end
    end

    initial begin
        t_meet want;
        t_pair p;
        int    limit;
        mismatches  = 0;
        meets_seen  = 0;
        hits_seen   = 0;
        idle_cycles = 0;
        sink_stalls = 1'b0;
        i_rst_n      = 1'b0;
        seg_in.valid <= 1'b0;
        seg_in.a_start_x <= '0; seg_in.a_start_y <= '0;
        seg_in.a_end_x   <= '0; seg_in.a_end_y   <= '0;
        seg_in.b_start_x <= '0; seg_in.b_start_y <= '0;
        seg_in.b_end_x   <= '0; seg_in.b_end_y   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, back to back with a receiver that never stalls.
        foreach (rows[i]) begin
            want = meet_point(rows[i].pair);
            if (rows[i].known && want !== rows[i].meet)
                $display("row %0d: table entry disagrees with the predictor", i);
            send_pair(rows[i].pair, rows[i].known ? rows[i].meet : want, 1'b0);
        end
        seg_in.valid <= 1'b0;

        // The sender holds off until the pipeline has drained completely.
        while (meet_queue.size() != 0) @(posedge i_clk);

        // Random pairs with bursts of idling on both sides, then a final
        // stretch where both sides run at full rate.
        sink_stalls = 1'b1;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 120) sink_stalls = 1'b0;
            p = rand_pair();
            send_pair(p, meet_point(p), n < N_RANDOM - 120);
        end
        seg_in.valid <= 1'b0;

        limit = 0;
        while (meet_queue.size() != 0 && limit < 100 * LATENCY) begin
            @(posedge i_clk);
            limit++;
        end
        repeat (LATENCY) @(posedge i_clk);

        $display("Checked %0d result transactions, %0d of them hits, over directed",
                 meets_seen, hits_seen);
        $display("crossing, collinear, parallel and zero-length pairs plus random ones.");
        if (mismatches == 0 && meet_queue.size() == 0) begin
            $display("segment_intersection regression: pass");
        end else begin
            $display("segment_intersection regression: fail");
        end
        $finish;
    end

endmodule
